FILE: src/edc_pkg.sv
`default_nettype none
package edc_pkg;

  localparam int unsigned DAY_W   = 16;
  localparam int unsigned MS_W    = 32;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned HOUR_W  = 11;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR  = 12'd1984;
  // Epoch year taken modulo 100 and modulo 400, for the century rules.
  localparam logic [6:0]        EPOCH_Y100  = 7'd84;
  localparam logic [8:0]        EPOCH_Y400  = 9'd384;
  localparam logic [6:0]        Y100_LAST   = 7'd99;
  localparam logic [8:0]        Y400_LAST   = 9'd399;

  localparam logic [DAY_W-1:0]  DAYS_YEAR   = 16'd365;
  localparam logic [DAY_W-1:0]  DAYS_LEAP   = 16'd366;

  localparam logic [MON_W-1:0]  FEB_IDX       = 4'd1;
  localparam logic [MON_W-1:0]  LAST_MON_IDX  = 4'd11;
  localparam logic [MON_W-1:0]  DEC_MONTH     = 4'd12;
  localparam logic [DOM_W-1:0]  DEC_LAST_DAY  = 5'd31;

  localparam logic [MS_W-1:0]   MS_PER_HOUR   = 32'd3600000;
  localparam logic [MS_W-1:0]   MS_PER_MINUTE = 32'd60000;
  localparam logic [MS_W-1:0]   MS_PER_SECOND = 32'd1000;

  // 3600000 = 2^7 * 28125, 60000 = 2^5 * 1875 and 1000 = 2^3 * 125. The low bits are
  // dropped first, then the odd factor is divided by a multiply with a rounded-up
  // reciprocal and a right shift. Each reciprocal is exact over its input range.
  localparam logic [25:0]       RECIP_HOUR  = 26'd39093747;  // ceil(2^40 / 28125)
  localparam logic [17:0]       RECIP_MIN   = 18'd143166;    // ceil(2^28 / 1875)
  localparam logic [13:0]       RECIP_SEC   = 14'd8389;      // ceil(2^20 / 125)
  localparam int unsigned       HOUR_SHIFT  = 40;
  localparam int unsigned       MIN_SHIFT   = 28;
  localparam int unsigned       SEC_SHIFT   = 20;

  // Steps of the time split: quotient, then remainder, for hours and minutes, then seconds.
  localparam logic [2:0] TS_HOURS    = 3'd0;
  localparam logic [2:0] TS_HOUR_REM = 3'd1;
  localparam logic [2:0] TS_MINUTES  = 3'd2;
  localparam logic [2:0] TS_MIN_REM  = 3'd3;
  localparam logic [2:0] TS_SECONDS  = 3'd4;
  localparam logic [2:0] TIME_END    = 3'd5;

  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
    logic time_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic year_more;
    logic month_last;
    logic time_done;
  } dp_sts_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_YEARS  = 4'b0010,
    S_MONTHS = 4'b0100,
    S_FIN    = 4'b1000
  } state_t;

  function automatic logic [DOM_W-1:0] month_len(input logic [MON_W-1:0] idx,
                                                 input logic leap);
    logic [DOM_W-1:0] len;
    case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      FEB_IDX:                                   len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: src/edc_dp.sv
`default_nettype none
module edc_dp (
  input  wire logic                           clk,
  input  wire logic [edc_pkg::DAY_W-1:0]      day_count,
  input  wire logic [edc_pkg::MS_W-1:0]       millis,
  input  wire edc_pkg::dp_cmd_t               cmd,
  output edc_pkg::dp_sts_t                    sts,
  output logic [edc_pkg::OUT_TDATA_W-1:0]     out_data
);
  import edc_pkg::*;

  logic [DAY_W-1:0]  rem_r,  rem_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [6:0]        y100_r, y100_nxt;
  logic [8:0]        y400_r, y400_nxt;
  logic [MON_W-1:0]  mon_r,  mon_nxt;
  logic [MS_W-1:0]   ms_r,   ms_nxt;
  logic [HOUR_W-1:0] hours_r, hours_nxt;
  logic [MIN_W-1:0]  min_r,  min_nxt;
  logic [SEC_W-1:0]  sec_r,  sec_nxt;
  logic [2:0]        tstep_r, tstep_nxt;
  logic [OUT_TDATA_W-1:0] out_r, out_nxt;

  logic             leap;
  logic [DAY_W-1:0] mlen;
  logic [50:0]       hour_prod;
  logic [34:0]       min_prod;
  logic [26:0]       sec_prod;
  logic [HOUR_W-1:0] hour_q;
  logic [MIN_W-1:0]  min_q;
  logic [SEC_W-1:0]  sec_q;
  logic [MS_W-1:0]   hour_back;
  logic [MS_W-1:0]   min_back;
  logic             rem_zero;
  logic [YEAR_W-1:0] res_year;
  logic [MON_W-1:0]  res_mon;
  logic [DOM_W-1:0]  res_day;

  assign leap     = ((year_r[1:0] == 2'd0) && (y100_r != 7'd0)) || (y400_r == 9'd0);
  assign mlen     = {{(DAY_W-DOM_W){1'b0}}, month_len(mon_r, leap)};
  assign rem_zero = (rem_r == '0);

  // Quotients by reciprocal multiplication; the remainder steps clear the upper bits
  // of ms_r before the next quotient is taken.
  assign hour_prod = {26'd0, ms_r[31:7]} * {25'd0, RECIP_HOUR};
  assign min_prod  = {18'd0, ms_r[21:5]} * {17'd0, RECIP_MIN};
  assign sec_prod  = {14'd0, ms_r[15:3]} * {13'd0, RECIP_SEC};
  assign hour_q    = HOUR_W'(hour_prod >> HOUR_SHIFT);
  assign min_q     = MIN_W'(min_prod >> MIN_SHIFT);
  assign sec_q     = SEC_W'(sec_prod >> SEC_SHIFT);
  assign hour_back = {{(MS_W-HOUR_W){1'b0}}, hours_r} * MS_PER_HOUR;
  assign min_back  = {{(MS_W-MIN_W){1'b0}}, min_r} * MS_PER_MINUTE;

  assign sts.year_more  = (rem_r > DAYS_YEAR);
  assign sts.month_last = !((rem_r > mlen) && (mon_r < LAST_MON_IDX));
  assign sts.time_done  = (tstep_r == TIME_END);

  // Day zero of a year means the last day of the year before.
  assign res_year = rem_zero ? (year_r - 12'd1) : year_r;
  assign res_mon  = rem_zero ? DEC_MONTH : (mon_r + 4'd1);
  assign res_day  = rem_zero ? DEC_LAST_DAY : rem_r[DOM_W-1:0];

  always_comb begin
    rem_nxt   = rem_r;
    year_nxt  = year_r;
    y100_nxt  = y100_r;
    y400_nxt  = y400_r;
    mon_nxt   = mon_r;
    ms_nxt    = ms_r;
    hours_nxt = hours_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    tstep_nxt = tstep_r;
    out_nxt   = out_r;
    if (cmd.load) begin
      rem_nxt   = day_count;
      year_nxt  = EPOCH_YEAR;
      y100_nxt  = EPOCH_Y100;
      y400_nxt  = EPOCH_Y400;
      mon_nxt   = '0;
      ms_nxt    = millis;
      tstep_nxt = '0;
    end else begin
      if (cmd.year_step) begin
        rem_nxt  = rem_r - (leap ? DAYS_LEAP : DAYS_YEAR);
        year_nxt = year_r + 12'd1;
        y100_nxt = (y100_r == Y100_LAST) ? 7'd0 : (y100_r + 7'd1);
        y400_nxt = (y400_r == Y400_LAST) ? 9'd0 : (y400_r + 9'd1);
      end
      if (cmd.month_step) begin
        rem_nxt = rem_r - mlen;
        mon_nxt = mon_r + 4'd1;
      end
      if (cmd.time_step) begin
        case (tstep_r)
          TS_HOURS:    hours_nxt = hour_q;
          TS_HOUR_REM: ms_nxt    = ms_r - hour_back;
          TS_MINUTES:  min_nxt   = min_q;
          TS_MIN_REM:  ms_nxt    = ms_r - min_back;
          TS_SECONDS:  sec_nxt   = sec_q;
          default: begin
          end
        endcase
        tstep_nxt = tstep_r + 3'd1;
      end
    end
    if (cmd.out_load) begin
      out_nxt = {4'd0, sec_r, min_r, hours_r, res_day, res_mon, res_year};
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    year_r  <= year_nxt;
    y100_r  <= y100_nxt;
    y400_r  <= y400_nxt;
    mon_r   <= mon_nxt;
    ms_r    <= ms_nxt;
    hours_r <= hours_nxt;
    min_r   <= min_nxt;
    sec_r   <= sec_nxt;
    tstep_r <= tstep_nxt;
    out_r   <= out_nxt;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

FILE: src/edc_ctrl.sv
`default_nettype none
module edc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire edc_pkg::dp_sts_t sts,
  output edc_pkg::dp_cmd_t      cmd
);
  import edc_pkg::*;

  state_t state_r, state_nxt;
  logic   oval_r, oval_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_YEARS;
        end
      end
      S_YEARS: begin
        cmd.time_step = !sts.time_done;
        if (sts.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          state_nxt = S_MONTHS;
        end
      end
      S_MONTHS: begin
        cmd.time_step = !sts.time_done;
        if (!sts.month_last) begin
          cmd.month_step = 1'b1;
        end else if (sts.time_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!oval_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    oval_nxt = oval_r;
    if (cmd.out_load) begin
      oval_nxt = 1'b1;
    end else if (out_tready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/epoch_days_ms_to_calendar_core.sv
// Converts a day count (1 Jan 1984 is day 1) and a millisecond count into a
// Gregorian date and an hours, minutes, seconds time; leftover milliseconds are dropped.
// The slave channel takes one beat per request and the master channel gives
// exactly one result beat per request, in order. Neither channel carries tlast or tuser.
// Sequence: the request is loaded, the year walk steps over each whole year from 1984
// (up to 179), the month walk steps over each month passed (up to 11), and then the
// result is loaded into the output register once that register is free. The
// millisecond count is split by five multiply and subtract steps that run alongside
// the year and month walk; the month walk is not left before the split is done. The
// year walk takes the longest for late dates.
// One request is worked on at a time; in_tready is high while the engine is idle,
// which begins in the cycle after the result is loaded.
// A finished result sits in the output register until the receiver takes it;
// a new request is accepted meanwhile, and its result waits for the register to free up.
// A synchronous active-low reset drops any request in flight and any result not taken.
`default_nettype none
module epoch_days_ms_to_calendar_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] day_count, [47:16] millis
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [11:0] year, [15:12] month, [20:16] day_of_month, [31:21] hours,
  // [37:32] minutes, [43:38] seconds, [47:44] zero
  output logic [47:0]      out_tdata
);
  import edc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller sequences the load, the year and month walks, the time split and the output handoff.
  edc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath holds the working remainders, the time split and the output register.
  edc_dp u_dp (
    .clk       (clk),
    .day_count (in_tdata[DAY_W-1:0]),
    .millis    (in_tdata[DAY_W+MS_W-1:DAY_W]),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_tdata)
  );

endmodule
`default_nettype wire

FILE: tb/tb_epoch_days_ms_to_calendar_core.sv
`default_nettype none
module tb_epoch_days_ms_to_calendar_core;
  import edc_pkg::*;

  // The limit leaves a wide margin over the slowest legal requests, even with both sides
  // idling between beats.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DOM_W-1:0]  mday;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
  } civil_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [15:0] day_count, [47:16] millis
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [11:0] year, [15:12] month, [20:16] day_of_month, [31:21] hours,
  // [37:32] minutes, [43:38] seconds, [47:44] zero
  logic [47:0] out_tdata;

  // Predicted calendar results, oldest first, in the order the requests were accepted.
  civil_t      pending_dates[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  // When these are clear, the corresponding side runs without any idle cycles.
  bit          sender_idles;
  bit          receiver_idles;

  epoch_days_ms_to_calendar_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------
  // Calendar arithmetic used by the predictor and by the stimulus.
  // ---------------------------------------------------------------------------------

  function automatic bit leap_year(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned days_in_year(input int unsigned yr);
    return leap_year(yr) ? 366 : 365;
  endfunction

  // Month index 0 is January.
  function automatic int unsigned days_in_month(input int unsigned mo, input int unsigned yr);
    int unsigned len;
    case (mo)
      1:           len = leap_year(yr) ? 29 : 28;
      3, 5, 8, 10: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  // Day count of 31 Dec of the given year. For 1983 this is day 0.
  function automatic int unsigned days_through(input int unsigned yr);
    int unsigned total;
    total = 0;
    for (int unsigned y = 32'(EPOCH_YEAR); y <= yr; y++) begin
      total += days_in_year(y);
    end
    return total;
  endfunction

  // Expected result for one request. Years are walked first while more than a common
  // year of days remains. An exact zero means the last day of the previous year.
  // Then months are walked, and December takes whatever is left.
  function automatic civil_t civil_from_epoch(input logic [DAY_W-1:0] day_count,
                                              input logic [MS_W-1:0] millis);
    civil_t      r;
    int unsigned left;
    int unsigned yr;
    int unsigned mo;
    logic [MS_W-1:0] part;
    left = 32'(day_count);
    yr   = 32'(EPOCH_YEAR);
    while (left > 365) begin
      left -= days_in_year(yr);
      yr++;
    end
    if (left == 0) begin
      r.year  = YEAR_W'(yr - 1);
      r.month = DEC_MONTH;
      r.mday  = DEC_LAST_DAY;
    end else begin
      mo = 0;
      while (mo < 11 && left > days_in_month(mo, yr)) begin
        left -= days_in_month(mo, yr);
        mo++;
      end
      r.year  = YEAR_W'(yr);
      r.month = MON_W'(mo + 1);
      r.mday  = DOM_W'(left);
    end
    r.hours   = HOUR_W'(millis / MS_PER_HOUR);
    part      = millis % MS_PER_HOUR;
    r.minutes = MIN_W'(part / MS_PER_MINUTE);
    part      = part % MS_PER_MINUTE;
    r.seconds = SEC_W'(part / MS_PER_SECOND);
    return r;
  endfunction

  // ---------------------------------------------------------------------------------
  // Random field choices. Uniform values are mixed with days and times close to year,
  // month, hour, minute and second boundaries, where an off-by-one would show.
  // ---------------------------------------------------------------------------------

  function automatic logic [DAY_W-1:0] pick_day_count();
    int          d;
    int unsigned yr;
    int unsigned mo;
    d = -1;
    case ($urandom_range(0, 5))
      0, 1: d = $urandom_range(0, 65535);
      2: begin
        d = days_through($urandom_range(1983, 2162)) + $urandom_range(0, 4) - 2;
      end
      3: begin
        yr = $urandom_range(1984, 2162);
        mo = $urandom_range(0, 11);
        d  = days_through(yr - 1);
        for (int unsigned m = 0; m < mo; m++) begin
          d += days_in_month(m, yr);
        end
        if ($urandom_range(0, 1) == 1) begin
          d += $urandom_range(0, 2);
        end else begin
          d += days_in_month(mo, yr) - 1 + $urandom_range(0, 2);
        end
      end
      4: d = $urandom_range(0, 800);
      default: d = $urandom_range(64000, 65535);
    endcase
    if (d < 0 || d > 65535) begin
      d = $urandom_range(0, 65535);
    end
    return DAY_W'(d);
  endfunction

  function automatic logic [MS_W-1:0] pick_millis();
    logic [MS_W-1:0] ms;
    case ($urandom_range(0, 6))
      0, 1: ms = $urandom;
      2: ms = MS_PER_HOUR * $urandom_range(0, 1193) + $urandom_range(0, 2) - 1;
      3: ms = MS_PER_MINUTE * $urandom_range(0, 71582) + $urandom_range(0, 2) - 1;
      4: ms = MS_PER_SECOND * $urandom_range(0, 4294967) + $urandom_range(0, 2) - 1;
      5: ms = 32'hFFFF_FFFF - $urandom_range(0, 4_000_000);
      default: ms = $urandom_range(0, 86_400_000);
    endcase
    return ms;
  endfunction

  // ---------------------------------------------------------------------------------
  // Request side. Inputs change on the falling edge. A beat counts as accepted at the
  // first rising edge where in_tready is seen high while in_tvalid is held. The task
  // returns on the falling edge after acceptance with in_tvalid still high. The next
  // call either lowers it for a gap or loads the next beat at once.
  // ---------------------------------------------------------------------------------

  task automatic send_request(input logic [DAY_W-1:0] day_count, input logic [MS_W-1:0] millis);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {millis, day_count};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_dates.push_back(civil_from_epoch(day_count, millis));
    @(negedge clk);
  endtask

  // Result side. With a nonzero stall the receiver drops out_tready and waits until a
  // result is offered. It then holds the result for the drawn number of cycles, so
  // the output register stays full while the next request is already running. With a
  // zero stall out_tready simply stays high.
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    forever begin
      stall = receiver_idles ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        out_tready = 1'b0;
        @(posedge clk);
        while (!out_tvalid) @(posedge clk);
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Every accepted result beat is unpacked and compared field by field with the oldest
  // prediction. A beat with nothing predicted is a failure on its own.
  always @(posedge clk) begin
    civil_t want;
    civil_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.year    = out_tdata[11:0];
      got.month   = out_tdata[15:12];
      got.mday    = out_tdata[20:16];
      got.hours   = out_tdata[31:21];
      got.minutes = out_tdata[37:32];
      got.seconds = out_tdata[43:38];
      if (pending_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result beat: %0d-%0d-%0d %0d:%0d:%0d", got.year, got.month,
                   got.mday, got.hours, got.minutes, got.seconds);
        end
      end else begin
        want = pending_dates.pop_front();
        if (got.year !== want.year || got.month !== want.month || got.mday !== want.mday ||
            got.hours !== want.hours || got.minutes !== want.minutes ||
            got.seconds !== want.seconds) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                     want.year, want.month, want.mday, want.hours, want.minutes, want.seconds,
                     got.year, got.month, got.mday, got.hours, got.minutes, got.seconds);
          end
        end
      end
    end
  end

  // A hung handshake must not run forever.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL epoch_days_ms_to_calendar_core");
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------

  // Date corners: the day before the epoch, the epoch itself, month ends in a leap
  // year, and the end of a leap year where the year walk leaves no days over. Also a
  // common year end, the 400-year and 100-year century rules, and the largest count.
  task automatic test_directed_dates();
    logic [DAY_W-1:0] corner_days[$];
    int unsigned      feb_2100;
    feb_2100 = days_through(2099) + 31;
    corner_days = '{16'd0, 16'd1, 16'd31, 16'd32, 16'd59, 16'd60, 16'd61, 16'd365,
                    16'd366, 16'd367,
                    DAY_W'(days_through(1985)), DAY_W'(days_through(1985) + 1),
                    DAY_W'(days_through(2000)), DAY_W'(days_through(2000) + 1),
                    DAY_W'(feb_2100 + 28), DAY_W'(feb_2100 + 29), 16'd65535};
    foreach (corner_days[i]) begin
      send_request(corner_days[i], $urandom);
    end
  endtask

  // Time corners: zero, the full 32-bit count, and each side of the hour, minute and
  // second steps.
  task automatic test_directed_times();
    logic [MS_W-1:0] corner_ms[$];
    corner_ms = '{32'd0, 32'hFFFF_FFFF, 32'd3599999, 32'd3600000, 32'd59999, 32'd60000,
                  32'd999, 32'd1000};
    foreach (corner_ms[i]) begin
      send_request(DAY_W'($urandom_range(0, 65535)), corner_ms[i]);
    end
  endtask

  // Random requests in stretches of 100. Each stretch picks whether either side idles,
  // so some run with both channels at full speed.
  task automatic test_random_requests(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        sender_idles   = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
      end
      send_request(pick_day_count(), pick_millis());
    end
  endtask

  // The sender holds off until every outstanding result is back. Then it sends a burst
  // with no gaps against a stalling receiver, so requests queue behind a full output
  // register.
  task automatic test_drain_then_burst();
    in_tvalid = 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    @(negedge clk);
    sender_idles   = 1'b0;
    receiver_idles = 1'b1;
    for (int unsigned i = 0; i < 50; i++) begin
      send_request(pick_day_count(), pick_millis());
    end
  endtask

  initial begin
    mismatch_count = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_directed_dates();
    test_directed_times();
    test_random_requests(700);
    test_drain_then_burst();
    test_random_requests(800);

    in_tvalid = 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("PASS epoch_days_ms_to_calendar_core");
    end else begin
      $display("FAIL epoch_days_ms_to_calendar_core");
    end
    $finish;
  end

endmodule
`default_nettype wire
